@@ design/sdoc_pkg.sv @@
// shared widths, constants and pipeline side-band types for the stick conditioner
package sdoc_pkg;

    // field widths
    localparam int RAW_W  = 8;
    localparam int DZ_W   = 7;
    localparam int OUT_W  = 8;
    localparam int CIDX_W = 1;

    // fixed point and scheme constants
    localparam int FRAC_W     = 16;
    localparam int FULL_SCALE = 85;
    localparam int OCT_NUM    = 16;
    localparam int OCT_DEN    = 69;
    localparam int OUTER_R2   = FULL_SCALE * FULL_SCALE;

    // internal widths
    localparam int MAG_W = 8;               // |raw|, up to 128
    localparam int SQ_W  = 2 * MAG_W;       // one axis squared
    localparam int TT_W  = 2 * DZ_W;        // deadzone squared
    localparam int R2_W  = 16;              // x*x + y*y, up to 32768
    localparam int LEN_W = 24;              // radius, Q16
    localparam int M_W   = 23;              // stretched radius, Q16, up to 85.0
    localparam int F_W   = 17;              // scale factor, Q16, up to 1.0
    localparam int A_W   = 25;              // scaled magnitude, Q16
    localparam int MX_W  = 32;              // octagon bound term
    localparam int SC_W  = 18;              // octagon scale, Q16

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_LEFT_DZ  = 1'b0,
        CFG_RIGHT_DZ = 1'b1
    } t_cfg_idx;

    // per item flags carried the whole way
    typedef struct packed {
        logic sx;
        logic sy;
        logic sel;
        logic kill;
    } t_tag;

    // through the radius square root
    typedef struct packed {
        t_tag             tag;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [DZ_W-1:0]  t;
        logic             outer;
        logic             tsat;
    } t_rad;

    // through the stretch divider
    typedef struct packed {
        t_rad             rad;
        logic [LEN_W-1:0] len;
    } t_mid;

    // through the factor divider
    typedef struct packed {
        t_tag             tag;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
    } t_scl;

    // through the octagon square root
    typedef struct packed {
        t_tag            tag;
        logic            octa;
        logic [A_W-1:0]  a;
        logic [A_W-1:0]  b;
        logic [MX_W-1:0] mx;
    } t_oct;

    // through the octagon divider
    typedef struct packed {
        t_tag           tag;
        logic           octa;
        logic [A_W-1:0] a;
        logic [A_W-1:0] b;
    } t_fin;

endpackage

@@ design/sdoc_intf.sv @@
// channel interfaces: sample in, result out, configuration write
interface sdoc_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [sdoc_pkg::RAW_W-1:0] raw_x;
    logic signed [sdoc_pkg::RAW_W-1:0] raw_y;
    logic                              stick_select;

    modport source(output valid, raw_x, raw_y, stick_select, input ready);
    modport sink(input valid, raw_x, raw_y, stick_select, output ready);
endinterface

interface sdoc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sdoc_pkg::OUT_W-1:0] out_x;
    logic signed [sdoc_pkg::OUT_W-1:0] out_y;
    logic                              out_select;

    modport source(output valid, out_x, out_y, out_select, input ready);
    modport sink(input valid, out_x, out_y, out_select, output ready);
endinterface

interface sdoc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sdoc_pkg::CIDX_W-1:0]      index;
    logic [sdoc_pkg::DZ_W-1:0]        data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ design/sdoc_isqrt_pipe.sv @@
// pipelined integer square root, one result bit per stage
module sdoc_isqrt_pipe #(
    parameter int RAD_W  = 48,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [RAD_W-1:0]      i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_vld,
    output logic [RAD_W/2-1:0]    o_root,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CMP_W  = REM_W + 2;

    logic              r_vld  [0:ROOT_W];
    logic [SIDE_W-1:0] r_side [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];
    logic [RAD_W-1:0]  r_rad  [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_root[0] <= '0;
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
        end
    end

    // one radicand bit pair per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [CMP_W-1:0] n_cur;
        logic [CMP_W-1:0] n_try;
        logic             n_bit;

        always_comb begin
            n_cur = {r_rem[k], r_rad[k][RAD_W-1 -: 2]};
            n_try = {2'b00, r_root[k], 2'b01};
            n_bit = (n_cur >= n_try);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], n_bit};
            end
        end

        if (k + 1 < ROOT_W) begin : g_carry
            logic [CMP_W-1:0] n_dif;

            always_comb begin
                n_dif = n_cur - n_try;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_bit ? n_dif[REM_W-1:0] : n_cur[REM_W-1:0];
                    r_rad[k+1] <= {r_rad[k][RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W];
    assign o_root = r_root[ROOT_W];
    assign o_side = r_side[ROOT_W];

endmodule

@@ design/sdoc_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage
module sdoc_div_pipe #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [0:NUM_W];
    logic [SIDE_W-1:0] r_side [0:NUM_W];
    logic [NUM_W-1:0]  r_quo  [0:NUM_W];
    logic [NUM_W-1:0]  r_num  [0:NUM_W-1];
    logic [DEN_W-1:0]  r_den  [0:NUM_W-1];
    logic [DEN_W-1:0]  r_rem  [0:NUM_W-1];

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_quo[0]  <= '0;
            r_num[0]  <= i_num;
            r_den[0]  <= i_den;
            r_rem[0]  <= '0;
        end
    end

    // one numerator bit per stage
    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [DEN_W:0] n_cur;
        logic           n_bit;

        always_comb begin
            n_cur = {r_rem[k], r_num[k][NUM_W-1]};
            n_bit = (n_cur >= {1'b0, r_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
                r_quo[k+1]  <= {r_quo[k][NUM_W-2:0], n_bit};
            end
        end

        if (k + 1 < NUM_W) begin : g_carry
            logic [DEN_W:0] n_dif;

            always_comb begin
                n_dif = n_cur - {1'b0, r_den[k]};
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_bit ? n_dif[DEN_W-1:0] : n_cur[DEN_W-1:0];
                    r_num[k+1] <= {r_num[k][NUM_W-2:0], 1'b0};
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    assign o_vld  = r_vld[NUM_W];
    assign o_quo  = r_quo[NUM_W];
    assign o_side = r_side[NUM_W];

endmodule

@@ design/stick_deadzone_octagon_clamp_unit.sv @@
// stick conditioner top level: radial deadzone, scaling and octagonal clamp
// throughput: one transaction per cycle; the 180-stage pipeline moves as one
//   and halts as a whole only while a finished result waits on the output
// the depth is set by the two square roots and three dividers, one bit per stage
// reset clears all valid bits and both deadzone registers to zero
module stick_deadzone_octagon_clamp_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sdoc_in_if.sink           i_in,
    sdoc_out_if.source        o_out,
    sdoc_cfg_if.sink          i_cfg
);
    import sdoc_pkg::*;

    localparam int RAD1_W = R2_W + 2 * FRAC_W;
    localparam int N1_W   = LEN_W + DZ_W;
    localparam int N2_W   = M_W + FRAC_W;
    localparam int AA_W   = 2 * A_W;
    localparam int RAD2_W = AA_W + 2;
    localparam int H_W    = RAD2_W / 2;
    localparam int HM_W   = H_W + DZ_W;
    localparam int N3_W   = HM_W + FRAC_W;
    localparam int P_W    = A_W + SC_W;
    localparam int MQ_W   = P_W - FRAC_W;
    localparam int MI_W   = MQ_W - FRAC_W;

    // magnitude in Q16 to signed output, saturated and truncated toward zero
    function automatic logic [OUT_W-1:0] f_finish(input logic [MQ_W-1:0] mag,
                                                  input logic neg, input logic kill);
        logic [MI_W-1:0]  whole;
        logic [OUT_W-1:0] sat;
        whole = mag[MQ_W-1:FRAC_W];
        sat   = (whole > MI_W'(FULL_SCALE)) ? OUT_W'(FULL_SCALE) : whole[OUT_W-1:0];
        if (kill) begin
            return '0;
        end
        return neg ? (~sat + OUT_W'(1)) : sat;
    endfunction

    logic en;

    // configuration registers
    logic [DZ_W-1:0] r_left_dz;
    logic [DZ_W-1:0] r_right_dz;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dz  <= '0;
            r_right_dz <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_LEFT_DZ:  r_left_dz  <= i_cfg.data;
                CFG_RIGHT_DZ: r_right_dz <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless the output holds a result not taken
    logic r_out_vld;
    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en && i_rst_n;

    // stage 1: magnitudes, signs, deadzone select and saturate
    t_rad            n1_rad;
    logic [DZ_W-1:0] n1_dz;
    logic            r1_vld;
    t_rad            r1_rad;

    always_comb begin
        n1_dz          = i_in.stick_select ? r_right_dz : r_left_dz;
        n1_rad         = '0;
        n1_rad.tag.sx  = i_in.raw_x[RAW_W-1];
        n1_rad.tag.sy  = i_in.raw_y[RAW_W-1];
        n1_rad.tag.sel = i_in.stick_select;
        n1_rad.ax      = i_in.raw_x[RAW_W-1] ? (MAG_W'(~i_in.raw_x) + MAG_W'(1))
                                             : MAG_W'(i_in.raw_x);
        n1_rad.ay      = i_in.raw_y[RAW_W-1] ? (MAG_W'(~i_in.raw_y) + MAG_W'(1))
                                             : MAG_W'(i_in.raw_y);
        n1_rad.t       = (n1_dz > DZ_W'(FULL_SCALE)) ? DZ_W'(FULL_SCALE) : n1_dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_rad <= n1_rad;
        end
    end

    // stage 2: squares
    logic            r2_vld;
    t_rad            r2_rad;
    logic [SQ_W-1:0] r2_sqx;
    logic [SQ_W-1:0] r2_sqy;
    logic [TT_W-1:0] r2_tt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_rad <= r1_rad;
            r2_sqx <= SQ_W'(r1_rad.ax) * SQ_W'(r1_rad.ax);
            r2_sqy <= SQ_W'(r1_rad.ay) * SQ_W'(r1_rad.ay);
            r2_tt  <= TT_W'(r1_rad.t) * TT_W'(r1_rad.t);
        end
    end

    // radius squared, deadzone and outer tests, into the radius root
    logic [R2_W-1:0] n3_r2;
    t_rad            n3_rad;

    always_comb begin
        n3_r2       = R2_W'(r2_sqx) + R2_W'(r2_sqy);
        n3_rad      = r2_rad;
        n3_rad.tag.kill = (n3_r2 == '0) || (n3_r2 < R2_W'(r2_tt));
        n3_rad.outer    = (n3_r2 > R2_W'(OUTER_R2));
        n3_rad.tsat     = (r2_rad.t == DZ_W'(FULL_SCALE));
    end

    logic             sq1_vld;
    logic [LEN_W-1:0] sq1_len;
    logic [$bits(t_rad)-1:0] sq1_side;

    sdoc_isqrt_pipe #(
        .RAD_W  (RAD1_W),
        .SIDE_W ($bits(t_rad))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r2_vld),
        .i_rad   ({n3_r2, {(2 * FRAC_W){1'b0}}}),
        .i_side  (n3_rad),
        .o_vld   (sq1_vld),
        .o_root  (sq1_len),
        .o_side  (sq1_side)
    );

    // stretch between deadzone and full scale: (len - t) * 85 / (85 - t)
    t_rad             sq1_rad;
    logic [LEN_W-1:0] n4_diff;
    logic [N1_W-1:0]  n4_num;
    logic [DZ_W-1:0]  n4_den;
    t_mid             n4_mid;

    always_comb begin
        sq1_rad = t_rad'(sq1_side);
        n4_diff = sq1_len - {1'b0, sq1_rad.t, {FRAC_W{1'b0}}};
        if (sq1_rad.tag.kill || sq1_rad.outer || sq1_rad.tsat) begin
            n4_num = '0;
        end else begin
            n4_num = N1_W'(n4_diff) * N1_W'(FULL_SCALE);
        end
        n4_den     = sq1_rad.tsat ? DZ_W'(1) : (DZ_W'(FULL_SCALE) - sq1_rad.t);
        n4_mid.rad = sq1_rad;
        n4_mid.len = sq1_len;
    end

    logic                    dv1_vld;
    logic [N1_W-1:0]         dv1_quo;
    logic [$bits(t_mid)-1:0] dv1_side;

    sdoc_div_pipe #(
        .NUM_W  (N1_W),
        .DEN_W  (DZ_W),
        .SIDE_W ($bits(t_mid))
    ) u_stretch_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq1_vld),
        .i_num   (n4_num),
        .i_den   (n4_den),
        .i_side  (n4_mid),
        .o_vld   (dv1_vld),
        .o_quo   (dv1_quo),
        .o_side  (dv1_side)
    );

    // scale factor: target length over radius, Q16
    t_mid             dv1_mid;
    logic [M_W-1:0]   n5_m;
    logic [N2_W-1:0]  n5_num;
    logic [LEN_W-1:0] n5_den;
    t_scl             n5_scl;

    always_comb begin
        dv1_mid = t_mid'(dv1_side);
        n5_m    = dv1_mid.rad.tsat ? (M_W'(FULL_SCALE) << FRAC_W) : dv1_quo[M_W-1:0];
        if (dv1_mid.rad.outer) begin
            n5_num = N2_W'(FULL_SCALE) << (2 * FRAC_W);
        end else begin
            n5_num = {n5_m, {FRAC_W{1'b0}}};
        end
        n5_den     = dv1_mid.rad.tag.kill ? LEN_W'(1) : dv1_mid.len;
        n5_scl.tag = dv1_mid.rad.tag;
        n5_scl.ax  = dv1_mid.rad.ax;
        n5_scl.ay  = dv1_mid.rad.ay;
    end

    logic                    dv2_vld;
    logic [N2_W-1:0]         dv2_quo;
    logic [$bits(t_scl)-1:0] dv2_side;

    sdoc_div_pipe #(
        .NUM_W  (N2_W),
        .DEN_W  (LEN_W),
        .SIDE_W ($bits(t_scl))
    ) u_factor_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (dv1_vld),
        .i_num   (n5_num),
        .i_den   (n5_den),
        .i_side  (n5_scl),
        .o_vld   (dv2_vld),
        .o_quo   (dv2_quo),
        .o_side  (dv2_side)
    );

    // stage 6: scaled magnitudes
    t_scl           dv2_scl;
    logic [F_W-1:0] n6_f;
    logic           r6_vld;
    t_tag           r6_tag;
    logic [A_W-1:0] r6_a;
    logic [A_W-1:0] r6_b;

    always_comb begin
        dv2_scl = t_scl'(dv2_side);
        n6_f    = dv2_quo[F_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= dv2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_tag <= dv2_scl.tag;
            r6_a   <= A_W'(dv2_scl.ax) * A_W'(n6_f);
            r6_b   <= A_W'(dv2_scl.ay) * A_W'(n6_f);
        end
    end

    // stage 7: squares and octagon bound terms
    logic            r7_vld;
    t_tag            r7_tag;
    logic            r7_octa;
    logic [A_W-1:0]  r7_a;
    logic [A_W-1:0]  r7_b;
    logic [AA_W-1:0] r7_aa;
    logic [AA_W-1:0] r7_bb;
    logic [MX_W-1:0] r7_m1;
    logic [MX_W-1:0] r7_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_tag  <= r6_tag;
            r7_octa <= (r6_a != '0) && (r6_b != '0);
            r7_a    <= r6_a;
            r7_b    <= r6_b;
            r7_aa   <= AA_W'(r6_a) * AA_W'(r6_a);
            r7_bb   <= AA_W'(r6_b) * AA_W'(r6_b);
            r7_m1   <= MX_W'(r6_a) * MX_W'(OCT_DEN) + MX_W'(r6_b) * MX_W'(OCT_NUM);
            r7_m2   <= MX_W'(r6_b) * MX_W'(OCT_DEN) + MX_W'(r6_a) * MX_W'(OCT_NUM);
        end
    end

    // hypotenuse squared and the larger bound term, into the octagon root
    logic [RAD2_W-1:0] n8_sum;
    t_oct              n8_oct;

    always_comb begin
        n8_sum      = RAD2_W'(r7_aa) + RAD2_W'(r7_bb);
        n8_oct.tag  = r7_tag;
        n8_oct.octa = r7_octa;
        n8_oct.a    = r7_a;
        n8_oct.b    = r7_b;
        n8_oct.mx   = (r7_m1 > r7_m2) ? r7_m1 : r7_m2;
    end

    logic                    sq2_vld;
    logic [H_W-1:0]          sq2_h;
    logic [$bits(t_oct)-1:0] sq2_side;

    sdoc_isqrt_pipe #(
        .RAD_W  (RAD2_W),
        .SIDE_W ($bits(t_oct))
    ) u_hyp_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r7_vld),
        .i_rad   (n8_sum),
        .i_side  (n8_oct),
        .o_vld   (sq2_vld),
        .o_root  (sq2_h),
        .o_side  (sq2_side)
    );

    // octagon scale: 69 * h / max term, Q16
    t_oct            sq2_oct;
    logic [HM_W-1:0] n9_hm;
    logic [N3_W-1:0] n9_num;
    logic [MX_W-1:0] n9_den;
    t_fin            n9_fin;

    always_comb begin
        sq2_oct     = t_oct'(sq2_side);
        n9_hm       = HM_W'(sq2_h) * HM_W'(OCT_DEN);
        n9_num      = {n9_hm, {FRAC_W{1'b0}}};
        n9_den      = sq2_oct.octa ? sq2_oct.mx : MX_W'(1);
        n9_fin.tag  = sq2_oct.tag;
        n9_fin.octa = sq2_oct.octa;
        n9_fin.a    = sq2_oct.a;
        n9_fin.b    = sq2_oct.b;
    end

    logic                    dv3_vld;
    logic [N3_W-1:0]         dv3_quo;
    logic [$bits(t_fin)-1:0] dv3_side;

    sdoc_div_pipe #(
        .NUM_W  (N3_W),
        .DEN_W  (MX_W),
        .SIDE_W ($bits(t_fin))
    ) u_oct_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq2_vld),
        .i_num   (n9_num),
        .i_den   (n9_den),
        .i_side  (n9_fin),
        .o_vld   (dv3_vld),
        .o_quo   (dv3_quo),
        .o_side  (dv3_side)
    );

    // stage 10: apply octagon scale
    t_fin            dv3_fin;
    logic [SC_W-1:0] n10_sc;
    logic            r10_vld;
    t_fin            r10_fin;
    logic [P_W-1:0]  r10_pa;
    logic [P_W-1:0]  r10_pb;

    always_comb begin
        dv3_fin = t_fin'(dv3_side);
        n10_sc  = dv3_quo[SC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (en) begin
            r10_vld <= dv3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_fin <= dv3_fin;
            r10_pa  <= P_W'(dv3_fin.a) * P_W'(n10_sc);
            r10_pb  <= P_W'(dv3_fin.b) * P_W'(n10_sc);
        end
    end

    // output register: pick magnitude, saturate, restore sign
    logic [MQ_W-1:0]  n11_ma;
    logic [MQ_W-1:0]  n11_mb;
    logic [OUT_W-1:0] r_out_x;
    logic [OUT_W-1:0] r_out_y;
    logic             r_out_sel;

    always_comb begin
        n11_ma = r10_fin.octa ? r10_pa[P_W-1:FRAC_W] : MQ_W'(r10_fin.a);
        n11_mb = r10_fin.octa ? r10_pb[P_W-1:FRAC_W] : MQ_W'(r10_fin.b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x   <= f_finish(n11_ma, r10_fin.tag.sx, r10_fin.tag.kill);
            r_out_y   <= f_finish(n11_mb, r10_fin.tag.sy, r10_fin.tag.kill);
            r_out_sel <= r10_fin.tag.sel;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_x      = r_out_x;
    assign o_out.out_y      = r_out_y;
    assign o_out.out_select = r_out_sel;

endmodule

@@ design/sdoc_checker.sv @@
// port-level checks for the stick conditioner, bound to the top level
module sdoc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [sdoc_pkg::OUT_W-1:0] i_out_x,
    input logic signed [sdoc_pkg::OUT_W-1:0] i_out_y,
    input logic                              i_out_select
);

    // nothing comes out of reset valid
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_select))
        else $error("stalled result changed");

    // results stay within full scale
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_x <= 8'sd85) && (i_out_x >= -8'sd85)
            && (i_out_y <= 8'sd85) && (i_out_y >= -8'sd85))
        else $error("result beyond full scale");

    // input only blocked by an untaken result
    a_in_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input blocked without output backpressure");

endmodule

bind stick_deadzone_octagon_clamp_unit sdoc_checker u_sdoc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_x      (o_out.out_x),
    .i_out_y      (o_out.out_y),
    .i_out_select (o_out.out_select)
);
